>>> hw/rtl/radial_falloff_force_accumulator_defines.svh
// ============================================================================
// Radial falloff force accumulator: assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ============================================================================
`ifndef RADIAL_FALLOFF_FORCE_ACCUMULATOR_DEFINES_SVH
`define RADIAL_FALLOFF_FORCE_ACCUMULATOR_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define RFFA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never be seen outside reset.
`define RFFA_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

>>> hw/rtl/rffa_pkg.sv
// ============================================================================
// Radial falloff force accumulator: package
// Word types, pipeline carry types, register indexes and depth constants.
// ============================================================================
`default_nettype none

package rffa_pkg;

    localparam int BIN_SHIFT   = 4;
    localparam int FRAC_BITS   = 4;
    localparam int BIN_POS     = FRAC_BITS + BIN_SHIFT;

    // Number of cells in each iterative section of the pipeline.
    localparam int SQRT_STEPS  = 29;
    localparam int FALL_STEPS  = 16;
    localparam int QUOT_STEPS  = 17;
    // Entry, square, distance, two multiply and one output register.
    localparam int LATENCY     = 6 + SQRT_STEPS + FALL_STEPS + QUOT_STEPS;

    localparam logic [2:0] REG_TARGET_X = 3'd0;
    localparam logic [2:0] REG_TARGET_Y = 3'd1;
    localparam logic [2:0] REG_RADIUS   = 3'd2;
    localparam logic [2:0] REG_SCALE    = 3'd3;
    localparam logic [2:0] REG_BINS_X   = 3'd4;
    localparam logic [2:0] REG_BINS_Y   = 3'd5;

    typedef struct packed {
        logic [19:0]        particle_x;
        logic [19:0]        particle_y;
        logic               slot_free;
        logic               force_excluded;
        logic signed [31:0] force_x_in;
        logic signed [31:0] force_y_in;
    } t_item;

    typedef struct packed {
        logic signed [31:0] force_x_out;
        logic signed [31:0] force_y_out;
        logic               force_applied;
        logic               saturated;
    } t_result;

    // Control and pass-through data that rides along every stage.
    typedef struct packed {
        logic               valid;
        logic               act;
        logic               neg_x;
        logic               neg_y;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
    } t_pass;

    // Square root section: two radicand bits are consumed per cell.
    typedef struct packed {
        t_pass       p;
        logic [19:0] mx;
        logic [19:0] my;
        logic [28:0] root;
        logic [31:0] rem;
        logic [57:0] v;
    } t_sq;

    // Falloff section: one quotient bit of (R - dq) / R per cell.
    typedef struct packed {
        t_pass       p;
        logic [19:0] mx;
        logic [19:0] my;
        logic [28:0] dq;
        logic [27:0] rem;
        logic [15:0] q;
    } t_fo;

    // Final division: one quotient bit per cell, x and y lanes side by side.
    typedef struct packed {
        t_pass       p;
        logic [28:0] dq;
        logic [36:0] rem_x;
        logic [36:0] rem_y;
        logic [16:0] low_x;
        logic [16:0] low_y;
        logic [16:0] q_x;
        logic [16:0] q_y;
    } t_qt;

endpackage

`default_nettype wire

>>> hw/rtl/radial_falloff_force_accumulator.sv
// ============================================================================
// Radial falloff force accumulator: top level
// Adds a radial force with linear falloff to one particle word per cycle.
// ============================================================================
// Stages: entry, square and distance, the cell chains, the multiplies, then output.
// Throughput: one word per cycle; busy never rises, as every stage is a register.
// The cell chains are 29 square root, 16 falloff and 17 quotient cells,
// each retiring one digit of its item.
// Reset is synchronous and active low; it empties the pipeline and restores the
// configuration registers to their reset values. The receiver cannot stall the result strobe.
`default_nettype none

module radial_falloff_force_accumulator (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  rffa_pkg::t_item    i_item,
    input  wire                i_cfg_we,
    input  wire  [2:0]         i_cfg_idx,
    input  wire  [19:0]        i_cfg_data,
    output logic               o_strobe,
    output rffa_pkg::t_result  o_result
);
    import rffa_pkg::*;

    // Configuration registers. The force centre and radius are Q16.4, the scale
    // is kept as its raw two's complement bits and read by its sign bit.
    logic [19:0] r_target_x;
    logic [19:0] r_target_y;
    logic [19:0] r_radius;
    logic [15:0] r_scale;
    logic [12:0] r_bins_x;
    logic [12:0] r_bins_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x <= '0;
            r_target_y <= '0;
            r_radius   <= '0;
            r_scale    <= '0;
            r_bins_x   <= 13'd64;
            r_bins_y   <= 13'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TARGET_X: r_target_x <= i_cfg_data;
                REG_TARGET_Y: r_target_y <= i_cfg_data;
                REG_RADIUS:   r_radius   <= i_cfg_data;
                REG_SCALE:    r_scale    <= i_cfg_data[15:0];
                REG_BINS_X:   r_bins_x   <= i_cfg_data[12:0];
                REG_BINS_Y:   r_bins_y   <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    // The pipeline never holds off a word.
    assign busy = 1'b0;

    logic w_accept;
    assign w_accept = start && !busy;

    // ------------------------------------------------------------------------
    // Entry stage: the offset from the centre is split into sign and magnitude,
    // and the eligibility of the particle (in use, not excluded, in the grid) is
    // settled here.
    // ------------------------------------------------------------------------
    typedef struct packed {
        t_pass       p;
        logic [19:0] mx;
        logic [19:0] my;
    } t_s0;

    typedef struct packed {
        t_pass       p;
        logic [19:0] mx;
        logic [19:0] my;
        logic [39:0] sqx;
        logic [39:0] sqy;
        logic [39:0] r2;
    } t_s1;

    typedef struct packed {
        t_pass       p;
        logic [28:0] dq;
        logic [35:0] px;
        logic [35:0] py;
    } t_m1;

    logic signed [20:0] w_dx;
    logic signed [20:0] w_dy;
    logic signed [20:0] w_ndx;
    logic signed [20:0] w_ndy;
    logic               w_in_grid;
    t_s0                n_s0;
    t_s0                r_s0;

    always_comb begin
        w_dx  = $signed({1'b0, i_item.particle_x}) - $signed({1'b0, r_target_x});
        w_dy  = $signed({1'b0, i_item.particle_y}) - $signed({1'b0, r_target_y});
        w_ndx = -w_dx;
        w_ndy = -w_dy;
        w_in_grid = ((i_item.particle_x >> BIN_POS) < {7'b0, r_bins_x})
                 && ((i_item.particle_y >> BIN_POS) < {7'b0, r_bins_y});
        n_s0.p.valid = w_accept;
        n_s0.p.act   = !i_item.slot_free && !i_item.force_excluded && w_in_grid;
        n_s0.p.neg_x = w_dx[20];
        n_s0.p.neg_y = w_dy[20];
        n_s0.p.fx    = i_item.force_x_in;
        n_s0.p.fy    = i_item.force_y_in;
        n_s0.mx      = w_dx[20] ? w_ndx[19:0] : w_dx[19:0];
        n_s0.my      = w_dy[20] ? w_ndy[19:0] : w_dy[19:0];
    end

    // ------------------------------------------------------------------------
    // Square stage: both squared offsets and the squared radius.
    // ------------------------------------------------------------------------
    t_s1 n_s1;
    t_s1 r_s1;

    always_comb begin
        n_s1.p   = r_s0.p;
        n_s1.mx  = r_s0.mx;
        n_s1.my  = r_s0.my;
        n_s1.sqx = {20'b0, r_s0.mx} * {20'b0, r_s0.mx};
        n_s1.sqy = {20'b0, r_s0.my} * {20'b0, r_s0.my};
        n_s1.r2  = {20'b0, r_radius} * {20'b0, r_radius};
    end

    // ------------------------------------------------------------------------
    // Distance stage: d^2 is formed and checked against the radius. A particle
    // sitting exactly on the centre, or on or beyond the radius, gets no force.
    // The radicand d^2 * 2^16 is loaded into the square root chain.
    // ------------------------------------------------------------------------
    logic [40:0] w_d2;
    t_sq         n_s2;
    t_sq         r_s2;

    always_comb begin
        w_d2       = {1'b0, r_s1.sqx} + {1'b0, r_s1.sqy};
        n_s2.p     = r_s1.p;
        n_s2.p.act = r_s1.p.act && (w_d2 != '0) && (w_d2 < {1'b0, r_s1.r2});
        n_s2.mx    = r_s1.mx;
        n_s2.my    = r_s1.my;
        n_s2.root  = '0;
        n_s2.rem   = '0;
        n_s2.v     = {1'b0, w_d2, 16'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s0 <= n_s0;
            r_s1 <= n_s1;
            r_s2 <= n_s2;
        end
    end

    // ------------------------------------------------------------------------
    // Square root chain: after the last cell the root is dq, the distance in
    // Q.12 units, floored.
    // ------------------------------------------------------------------------
    t_sq w_sq [0:SQRT_STEPS];
    assign w_sq[0] = r_s2;

    for (genvar gi = 0; gi < SQRT_STEPS; gi++) begin : g_sqrt
        rffa_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (w_sq[gi]),
            .o_cell  (w_sq[gi + 1])
        );
    end

    // ------------------------------------------------------------------------
    // Falloff chain: F = floor((R - dq) * 2^16 / R) with R = radius * 2^8. For a
    // particle inside the radius dq < R, so the partial remainder starts below R
    // and sixteen quotient bits cover the whole fraction.
    // ------------------------------------------------------------------------
    logic [27:0] w_rr;
    logic [28:0] w_rdiff;
    t_fo         w_fo_head;
    t_fo         w_fo [0:FALL_STEPS];

    always_comb begin
        w_rr           = {r_radius, 8'b0};
        w_rdiff        = {1'b0, w_rr} - w_sq[SQRT_STEPS].root;
        w_fo_head.p    = w_sq[SQRT_STEPS].p;
        w_fo_head.mx   = w_sq[SQRT_STEPS].mx;
        w_fo_head.my   = w_sq[SQRT_STEPS].my;
        w_fo_head.dq   = w_sq[SQRT_STEPS].root;
        w_fo_head.rem  = w_rdiff[27:0];
        w_fo_head.q    = '0;
    end

    assign w_fo[0] = w_fo_head;

    for (genvar gj = 0; gj < FALL_STEPS; gj++) begin : g_fall
        rffa_fall_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rr    (w_rr),
            .i_cell  (w_fo[gj]),
            .o_cell  (w_fo[gj + 1])
        );
    end

    // ------------------------------------------------------------------------
    // Multiply stages: |d| * F, then times |scale|, plus half the divisor so the
    // division below rounds to nearest with ties away from zero. The sign of the
    // result is the sign of the offset times the sign of the scale.
    // ------------------------------------------------------------------------
    logic [15:0] w_ms;
    logic [51:0] w_nx;
    logic [51:0] w_ny;
    t_m1         n_m1;
    t_m1         r_m1;
    t_qt         n_m2;
    t_qt         r_m2;

    always_comb begin
        n_m1.p  = w_fo[FALL_STEPS].p;
        n_m1.dq = w_fo[FALL_STEPS].dq;
        n_m1.px = {16'b0, w_fo[FALL_STEPS].mx} * {20'b0, w_fo[FALL_STEPS].q};
        n_m1.py = {16'b0, w_fo[FALL_STEPS].my} * {20'b0, w_fo[FALL_STEPS].q};
    end

    always_comb begin
        w_ms = r_scale[15] ? (~r_scale + 16'd1) : r_scale;
        w_nx = ({16'b0, r_m1.px} * {36'b0, w_ms}) + {16'b0, r_m1.dq, 7'b0};
        w_ny = ({16'b0, r_m1.py} * {36'b0, w_ms}) + {16'b0, r_m1.dq, 7'b0};
        n_m2.p       = r_m1.p;
        n_m2.p.neg_x = r_m1.p.neg_x ^ r_scale[15];
        n_m2.p.neg_y = r_m1.p.neg_y ^ r_scale[15];
        n_m2.dq      = r_m1.dq;
        n_m2.rem_x   = {2'b0, w_nx[51:17]};
        n_m2.rem_y   = {2'b0, w_ny[51:17]};
        n_m2.low_x   = w_nx[16:0];
        n_m2.low_y   = w_ny[16:0];
        n_m2.q_x     = '0;
        n_m2.q_y     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1 <= '0;
            r_m2 <= '0;
        end else begin
            r_m1 <= n_m1;
            r_m2 <= n_m2;
        end
    end

    // ------------------------------------------------------------------------
    // Quotient chain: divides by dq * 2^8. The magnitude of the added force
    // always stays below 2^17, so seventeen cells give the full quotient.
    // ------------------------------------------------------------------------
    t_qt w_qt [0:QUOT_STEPS];
    assign w_qt[0] = r_m2;

    for (genvar gk = 0; gk < QUOT_STEPS; gk++) begin : g_quot
        rffa_quot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (w_qt[gk]),
            .o_cell  (w_qt[gk + 1])
        );
    end

    // ------------------------------------------------------------------------
    // Output stage: signed add to the incoming accumulators with saturation.
    // A particle that takes no part passes its forces through with both flags
    // clear.
    // ------------------------------------------------------------------------
    logic [17:0]        w_qx;
    logic [17:0]        w_qy;
    logic [17:0]        w_delta_x;
    logic [17:0]        w_delta_y;
    logic [33:0]        w_sum_x;
    logic [33:0]        w_sum_y;
    logic               w_clip_x;
    logic               w_clip_y;
    t_pass              w_fin;
    logic               n_strobe;
    logic               r_strobe;
    t_result            n_result;
    t_result            r_result;

    always_comb begin
        w_fin     = w_qt[QUOT_STEPS].p;
        w_qx      = {1'b0, w_qt[QUOT_STEPS].q_x};
        w_qy      = {1'b0, w_qt[QUOT_STEPS].q_y};
        w_delta_x = w_fin.neg_x ? (~w_qx + 18'd1) : w_qx;
        w_delta_y = w_fin.neg_y ? (~w_qy + 18'd1) : w_qy;
        w_sum_x   = {{2{w_fin.fx[31]}}, w_fin.fx} + {{16{w_delta_x[17]}}, w_delta_x};
        w_sum_y   = {{2{w_fin.fy[31]}}, w_fin.fy} + {{16{w_delta_y[17]}}, w_delta_y};
        w_clip_x  = (w_sum_x[33:31] != 3'b000) && (w_sum_x[33:31] != 3'b111);
        w_clip_y  = (w_sum_y[33:31] != 3'b000) && (w_sum_y[33:31] != 3'b111);

        n_strobe = w_fin.valid;
        if (w_fin.act) begin
            if (w_clip_x) begin
                n_result.force_x_out = w_sum_x[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                n_result.force_x_out = $signed(w_sum_x[31:0]);
            end
            if (w_clip_y) begin
                n_result.force_y_out = w_sum_y[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                n_result.force_y_out = $signed(w_sum_y[31:0]);
            end
            n_result.force_applied = 1'b1;
            n_result.saturated     = w_clip_x || w_clip_y;
        end else begin
            n_result.force_x_out   = w_fin.fx;
            n_result.force_y_out   = w_fin.fy;
            n_result.force_applied = 1'b0;
            n_result.saturated     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> hw/rtl/rffa_sqrt_cell.sv
// ============================================================================
// Radial falloff force accumulator: square root cell
// One digit step of a restoring integer square root, registered.
// ============================================================================
`default_nettype none

module rffa_sqrt_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  rffa_pkg::t_sq     i_cell,
    output rffa_pkg::t_sq     o_cell
);
    import rffa_pkg::*;

    logic [31:0] w_rem;
    logic [31:0] w_trial;
    logic        w_take;
    t_sq         n_cell;
    t_sq         r_cell;

    always_comb begin
        n_cell  = i_cell;
        w_rem   = {i_cell.rem[29:0], i_cell.v[57:56]};
        w_trial = {1'b0, i_cell.root, 2'b01};
        w_take  = (w_rem >= w_trial);
        n_cell.v = {i_cell.v[55:0], 2'b00};
        if (w_take) begin
            n_cell.rem  = w_rem - w_trial;
            n_cell.root = {i_cell.root[27:0], 1'b1};
        end else begin
            n_cell.rem  = w_rem;
            n_cell.root = {i_cell.root[27:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

>>> hw/rtl/rffa_fall_cell.sv
// ============================================================================
// Radial falloff force accumulator: falloff divider cell
// One restoring division step of the falloff fraction, registered.
// ============================================================================
`default_nettype none

module rffa_fall_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [27:0]       i_rr,
    input  rffa_pkg::t_fo     i_cell,
    output rffa_pkg::t_fo     o_cell
);
    import rffa_pkg::*;

    logic [28:0] w_rem;
    logic [28:0] w_diff;
    logic        w_take;
    t_fo         n_cell;
    t_fo         r_cell;

    always_comb begin
        n_cell = i_cell;
        w_rem  = {i_cell.rem, 1'b0};
        w_diff = w_rem - {1'b0, i_rr};
        w_take = (w_rem >= {1'b0, i_rr});
        n_cell.rem = w_take ? w_diff[27:0] : w_rem[27:0];
        n_cell.q   = {i_cell.q[14:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

>>> hw/rtl/rffa_quot_cell.sv
// ============================================================================
// Radial falloff force accumulator: force quotient cell
// One long-division step for the x and y force lanes, registered.
// ============================================================================
`default_nettype none

module rffa_quot_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  rffa_pkg::t_qt     i_cell,
    output rffa_pkg::t_qt     o_cell
);
    import rffa_pkg::*;

    logic [37:0] w_den;
    logic [37:0] w_rx;
    logic [37:0] w_ry;
    logic        w_tx;
    logic        w_ty;
    t_qt         n_cell;
    t_qt         r_cell;

    always_comb begin
        n_cell = i_cell;
        w_den  = {1'b0, i_cell.dq, 8'b0};
        w_rx   = {i_cell.rem_x, i_cell.low_x[16]};
        w_ry   = {i_cell.rem_y, i_cell.low_y[16]};
        w_tx   = (w_rx >= w_den);
        w_ty   = (w_ry >= w_den);
        n_cell.rem_x = w_tx ? 37'(w_rx - w_den) : w_rx[36:0];
        n_cell.rem_y = w_ty ? 37'(w_ry - w_den) : w_ry[36:0];
        n_cell.low_x = {i_cell.low_x[15:0], 1'b0};
        n_cell.low_y = {i_cell.low_y[15:0], 1'b0};
        n_cell.q_x   = {i_cell.q_x[15:0], w_tx};
        n_cell.q_y   = {i_cell.q_y[15:0], w_ty};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

>>> hw/rtl/rffa_checker.sv
// ============================================================================
// Radial falloff force accumulator: port checker
// Watches the top level's ports for timing and pass-through consistency.
// ============================================================================
`default_nettype none

`include "radial_falloff_force_accumulator_defines.svh"

module rffa_checker (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    input  wire                busy,
    input  rffa_pkg::t_item    i_item,
    input  wire                o_strobe,
    input  rffa_pkg::t_result  o_result
);
    import rffa_pkg::*;

    localparam int WARM_W = $clog2(LATENCY + 1);

    // Counts clean cycles since reset so that looks into the past stay valid.
    logic [WARM_W-1:0] r_warm;
    logic              w_warm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= '0;
        end else if (r_warm != WARM_W'(LATENCY)) begin
            r_warm <= r_warm + 1'b1;
        end
    end

    assign w_warm = (r_warm == WARM_W'(LATENCY));

    `RFFA_ASSERT_NEVER(a_never_busy, busy, "busy raised on a streaming pipeline")

    `RFFA_ASSERT_IMP(a_strobe_latency, w_warm, o_strobe == $past(start && !busy, LATENCY), "result word out of step with accepted word")

    `RFFA_ASSERT_IMP(a_sat_needs_force, o_strobe && o_result.saturated, o_result.force_applied, "saturation reported without force")

    `RFFA_ASSERT_IMP(a_pass_through, w_warm && o_strobe && !o_result.force_applied, (o_result.force_x_out == $past(i_item.force_x_in, LATENCY)) && (o_result.force_y_out == $past(i_item.force_y_in, LATENCY)), "forces altered without force applied")

endmodule

bind radial_falloff_force_accumulator rffa_checker u_rffa_checker (.*);

`default_nettype wire
